@@ hdl/triss_pkg.sv @@
// Shared types, constants and helpers of the triangle scanline span block.
// Used by every module under hdl; depends on nothing.
package triss_pkg;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned COLOR_BITS  = 16;
  localparam int unsigned PROD_BITS   = 2 * COORD_BITS;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  // divider input register, one stage per quotient bit, output register
  localparam int unsigned DIV_LATENCY = COORD_BITS + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] ucoord_t;
  typedef logic        [COLOR_BITS-1:0] color_t;

  typedef struct packed {
    coord_t  vertex_a_x;
    coord_t  vertex_a_y;
    coord_t  vertex_b_x;
    coord_t  vertex_b_y;
    coord_t  vertex_c_x;
    coord_t  vertex_c_y;
    ucoord_t row_offset;
  } cmd_t;

  typedef struct packed {
    coord_t span_y;
    coord_t span_left;
    coord_t span_right;
    color_t span_color;
  } span_t;

  typedef struct packed {
    coord_t  ax;
    coord_t  ay;
    coord_t  bx;
    coord_t  by;
    coord_t  cx;
    coord_t  cy;
    ucoord_t row;
  } sorted_t;

  // One edge interpolation: xs + sign * (mag * k) / h
  typedef struct packed {
    coord_t  xs;
    logic    neg;
    ucoord_t mag;
    ucoord_t k;
    ucoord_t h;
  } lane_t;

  typedef struct packed {
    coord_t y;
    lane_t  long_l;
    lane_t  short_l;
  } job_t;

  function automatic lane_t make_lane(coord_t xs, coord_t xe, ucoord_t k, ucoord_t h);
    logic signed [COORD_BITS:0] d;
    logic        [COORD_BITS:0] a;
    lane_t                      l;
    d     = $signed({xe[COORD_BITS-1], xe}) - $signed({xs[COORD_BITS-1], xs});
    a     = d[COORD_BITS] ? (~d + 1'b1) : d;
    l.xs  = xs;
    l.neg = d[COORD_BITS];
    l.mag = a[COORD_BITS-1:0];
    l.k   = k;
    l.h   = (h == '0) ? ucoord_t'(1) : h;
    return l;
  endfunction

endpackage

@@ hdl/triss_front.sv @@
// Front end: takes a command, sorts the vertices by y, then classifies the row
// and builds the job with its long and short edge lanes. Depends on triss_pkg.
module triss_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  triss_pkg::cmd_t cmd_i,
  input  logic            full_i,
  output logic            busy_o,
  output logic            push_o,
  output triss_pkg::job_t job_o
);
  import triss_pkg::*;

  sorted_t srt;
  sorted_t f_q;
  logic    f_v_q;
  logic    keep;
  logic    advance;

  always_comb begin
    coord_t tx;
    coord_t ty;
    tx      = '0;
    ty      = '0;
    srt.ax  = cmd_i.vertex_a_x;
    srt.ay  = cmd_i.vertex_a_y;
    srt.bx  = cmd_i.vertex_b_x;
    srt.by  = cmd_i.vertex_b_y;
    srt.cx  = cmd_i.vertex_c_x;
    srt.cy  = cmd_i.vertex_c_y;
    srt.row = cmd_i.row_offset;
    if (srt.ay > srt.by) begin
      tx = srt.ax; ty = srt.ay;
      srt.ax = srt.bx; srt.ay = srt.by;
      srt.bx = tx; srt.by = ty;
    end
    if (srt.ay > srt.cy) begin
      tx = srt.ax; ty = srt.ay;
      srt.ax = srt.cx; srt.ay = srt.cy;
      srt.cx = tx; srt.cy = ty;
    end
    if (srt.by > srt.cy) begin
      tx = srt.bx; ty = srt.by;
      srt.bx = srt.cx; srt.by = srt.cy;
      srt.cx = tx; srt.cy = ty;
    end
  end

  always_comb begin
    logic signed [COORD_BITS:0] hs;
    logic signed [COORD_BITS:0] us;
    logic signed [COORD_BITS:0] ls;
    ucoord_t height;
    ucoord_t upper;
    ucoord_t lower_h;
    logic    lower;
    hs      = $signed({f_q.cy[COORD_BITS-1], f_q.cy}) - $signed({f_q.ay[COORD_BITS-1], f_q.ay});
    us      = $signed({f_q.by[COORD_BITS-1], f_q.by}) - $signed({f_q.ay[COORD_BITS-1], f_q.ay});
    ls      = $signed({f_q.cy[COORD_BITS-1], f_q.cy}) - $signed({f_q.by[COORD_BITS-1], f_q.by});
    height  = hs[COORD_BITS-1:0];
    upper   = us[COORD_BITS-1:0];
    lower_h = ls[COORD_BITS-1:0];
    keep    = (height != '0) && (f_q.row <= height);
    lower   = (f_q.row > upper) || (upper == '0);
    job_o.y      = coord_t'(f_q.ay + f_q.row);
    job_o.long_l = make_lane(f_q.ax, f_q.cx, f_q.row, height);
    if (lower) begin
      job_o.short_l = make_lane(f_q.bx, f_q.cx, ucoord_t'(f_q.row - upper), lower_h);
    end else begin
      job_o.short_l = make_lane(f_q.ax, f_q.bx, f_q.row, upper);
    end
  end

  assign advance = !f_v_q || !keep || !full_i;
  assign busy_o  = !advance;
  assign push_o  = f_v_q && keep && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (advance) begin
      f_v_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && advance) begin
      f_q <= srt;
    end
  end

endmodule

@@ hdl/triss_queue.sv @@
// Small job queue between front and back end.
// Depends on triss_pkg.
module triss_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  triss_pkg::job_t data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output triss_pkg::job_t data_o
);
  import triss_pkg::*;

  job_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wp_q;
  logic [QPTR_BITS-1:0] rp_q;
  logic [QPTR_BITS:0]   cnt_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

@@ hdl/triss_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, then signed add of
// the edge start x. Depends on triss_pkg.
module triss_div (
  input  logic                              clk_i,
  input  logic [triss_pkg::PROD_BITS-1:0]   dividend_i,
  input  triss_pkg::ucoord_t                divisor_i,
  input  logic                              neg_i,
  input  triss_pkg::coord_t                 xs_i,
  output triss_pkg::coord_t                 x_o
);
  import triss_pkg::*;

  ucoord_t rem_q [COORD_BITS+1];
  ucoord_t lo_q  [COORD_BITS+1];
  ucoord_t quo_q [COORD_BITS+1];
  ucoord_t h_q   [COORD_BITS+1];
  logic    neg_q [COORD_BITS+1];
  coord_t  xs_q  [COORD_BITS+1];
  coord_t  x_q;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= dividend_i[PROD_BITS-1:COORD_BITS];
    lo_q[0]  <= dividend_i[COORD_BITS-1:0];
    quo_q[0] <= '0;
    h_q[0]   <= divisor_i;
    neg_q[0] <= neg_i;
    xs_q[0]  <= xs_i;
  end

  for (genvar j = 0; j < COORD_BITS; j++) begin : g_step
    logic [COORD_BITS:0] t;
    logic [COORD_BITS:0] diff;
    logic                ge;
    assign t    = {rem_q[j], lo_q[j][COORD_BITS-1]};
    assign diff = t - {1'b0, h_q[j]};
    assign ge   = (t >= {1'b0, h_q[j]});
    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= ge ? diff[COORD_BITS-1:0] : t[COORD_BITS-1:0];
      lo_q[j+1]  <= lo_q[j] << 1;
      quo_q[j+1] <= {quo_q[j][COORD_BITS-2:0], ge};
      h_q[j+1]   <= h_q[j];
      neg_q[j+1] <= neg_q[j];
      xs_q[j+1]  <= xs_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [COORD_BITS:0] qx;
    logic [COORD_BITS:0] sq;
    logic [COORD_BITS:0] sum;
    qx  = {1'b0, quo_q[COORD_BITS]};
    sq  = neg_q[COORD_BITS] ? (~qx + 1'b1) : qx;
    sum = {xs_q[COORD_BITS][COORD_BITS-1], xs_q[COORD_BITS]} + sq;
    x_q <= sum[COORD_BITS-1:0];
  end

  assign x_o = x_q;

endmodule

@@ hdl/triss_back.sv @@
// Back end: multiplies, divides both edges in parallel, orders the x ends and
// registers the span. Depends on triss_pkg and triss_div.
module triss_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  triss_pkg::job_t   job_i,
  input  triss_pkg::color_t color_i,
  output logic              pop_o,
  output logic              span_valid_o,
  output triss_pkg::span_t  span_o
);
  import triss_pkg::*;

  logic                 m_v_q;
  coord_t               m_y_q;
  logic [PROD_BITS-1:0] m_lp_q;
  logic [PROD_BITS-1:0] m_sp_q;
  lane_t                m_l_q;
  lane_t                m_s_q;
  logic                 dl_v_q [DIV_LATENCY];
  coord_t               dl_y_q [DIV_LATENCY];
  coord_t               long_x;
  coord_t               short_x;
  logic                 out_v_q;
  span_t                out_q;

  assign pop_o = !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q   <= 1'b0;
      out_v_q <= 1'b0;
      for (int i = 0; i < DIV_LATENCY; i++) dl_v_q[i] <= 1'b0;
    end else begin
      m_v_q     <= !empty_i;
      dl_v_q[0] <= m_v_q;
      for (int i = 1; i < DIV_LATENCY; i++) dl_v_q[i] <= dl_v_q[i-1];
      out_v_q   <= dl_v_q[DIV_LATENCY-1];
    end
  end

  always_ff @(posedge clk_i) begin
    m_y_q  <= job_i.y;
    m_l_q  <= job_i.long_l;
    m_s_q  <= job_i.short_l;
    m_lp_q <= PROD_BITS'(job_i.long_l.mag) * PROD_BITS'(job_i.long_l.k);
    m_sp_q <= PROD_BITS'(job_i.short_l.mag) * PROD_BITS'(job_i.short_l.k);
    dl_y_q[0] <= m_y_q;
    for (int i = 1; i < DIV_LATENCY; i++) dl_y_q[i] <= dl_y_q[i-1];
  end

  triss_div u_div_long (
    .clk_i      (clk_i),
    .dividend_i (m_lp_q),
    .divisor_i  (m_l_q.h),
    .neg_i      (m_l_q.neg),
    .xs_i       (m_l_q.xs),
    .x_o        (long_x)
  );

  triss_div u_div_short (
    .clk_i      (clk_i),
    .dividend_i (m_sp_q),
    .divisor_i  (m_s_q.h),
    .neg_i      (m_s_q.neg),
    .xs_i       (m_s_q.xs),
    .x_o        (short_x)
  );

  always_ff @(posedge clk_i) begin
    out_q.span_y     <= dl_y_q[DIV_LATENCY-1];
    out_q.span_left  <= (long_x > short_x) ? short_x : long_x;
    out_q.span_right <= (long_x > short_x) ? long_x : short_x;
    out_q.span_color <= color_i;
  end

  assign span_valid_o = out_v_q;
  assign span_o       = out_q;

endmodule

@@ hdl/triangle_scanline_span.sv @@
// Top level of the triangle scanline span block: config register, front end,
// job queue and back end. Depends on triss_pkg, triss_front, triss_queue, triss_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------
//   command  | start / busy              | cmd_i
//   span     | span_valid_o (strobe)     | span_o
//   config   | cfg_we_i                  | cfg_wdata_i
//
// One item per cycle while busy is low; an item passes the front register, the queue,
// the multiply register, the bit-per-stage dividers and the output register.
// Items with a flat triangle or a row past the bottom give no span.
// busy only rises if the job queue is full; the back end drains it every cycle.
// Reset clears all valid state and the fill color.
module triangle_scanline_span (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  triss_pkg::cmd_t   cmd_i,
  input  logic              cfg_we_i,
  input  triss_pkg::color_t cfg_wdata_i,
  output logic              span_valid_o,
  output triss_pkg::span_t  span_o
);
  import triss_pkg::*;

  color_t color_q;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  job_t   fjob;
  job_t   qjob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  triss_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .full_i  (full),
    .busy_o  (busy),
    .push_o  (push),
    .job_o   (fjob)
  );

  triss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fjob),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .data_o  (qjob)
  );

  triss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (qjob),
    .color_i      (color_q),
    .pop_o        (pop),
    .span_valid_o (span_valid_o),
    .span_o       (span_o)
  );

  a_span_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o |-> (span_o.span_left <= span_o.span_right))
    else $error("span ends out of order");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("push into full queue");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pop)
    else $error("back end left a job queued");

endmodule
